### sv/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion helpers; empty when NO_ASSERTIONS is set.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS
`define KHB_ASSERT(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);
`define KHB_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define KHB_ASSERT(lbl, clk, rstn, prop, msg)
`define KHB_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif

`endif

### sv/khb_pkg.sv
// ----------------------------------------------------------------------------
// khb_pkg
// Shared types, constants and the per-byte hash step.
// ----------------------------------------------------------------------------
package khb_pkg;

    localparam int unsigned HASH_W     = 32;
    localparam int unsigned BYTE_W     = 8;
    localparam int unsigned CFG_IDX_W  = 8;

    localparam logic [HASH_W-1:0] HASH_MASK     = 32'h7fff_ffff;
    localparam logic [HASH_W-1:0] SEED_RESET    = 32'h000f_422f;
    localparam logic [HASH_W-1:0] BUCKETS_RESET = 32'd2047;

    localparam logic [CFG_IDX_W-1:0] CFG_HASH_SEED    = 8'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_BUCKET_COUNT = 8'd1;

    typedef struct packed {
        logic [HASH_W-1:0] hash;
        logic [HASH_W-1:0] modulus;
    } khb_entry_t;

    typedef struct packed {
        logic full;
        logic empty;
    } khb_queue_stat_t;

    typedef struct packed {
        logic              busy;
        logic [HASH_W-1:0] divisor;
    } khb_back_stat_t;

    function automatic logic [HASH_W-1:0] mix_byte(
        input logic [HASH_W-1:0] h,
        input logic [BYTE_W-1:0] b
    );
        logic [HASH_W-1:0] t;
        t = h + (h << 5);
        t = t ^ {{(HASH_W-BYTE_W){1'b0}}, b};
        return t & HASH_MASK;
    endfunction

endpackage

### sv/khb_front.sv
// ----------------------------------------------------------------------------
// khb_front
// Byte intake: runs the hash one byte per item, emits one entry per key.
// ----------------------------------------------------------------------------
module khb_front (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic [khb_pkg::BYTE_W-1:0]    s_key_byte,
    input  logic                          s_byte_present,
    input  logic                          s_key_end,
    input  logic [khb_pkg::HASH_W-1:0]    hash_seed,
    input  logic [khb_pkg::HASH_W-1:0]    bucket_count,
    input  khb_pkg::khb_queue_stat_t      q_stat,
    output logic                          q_push,
    output khb_pkg::khb_entry_t           q_entry
);
    import khb_pkg::*;

    logic [HASH_W-1:0] hash_reg, hash_next;
    logic              start_reg, start_next;
    logic [HASH_W-1:0] base;
    logic              accept;

    assign s_ready = !q_stat.full;
    assign accept  = s_valid && s_ready;
    assign base    = start_reg ? hash_seed : hash_reg;

    always_comb begin
        hash_next  = hash_reg;
        start_next = start_reg;
        if (accept) begin
            hash_next  = s_byte_present ? mix_byte(base, s_key_byte) : base;
            start_next = s_key_end;
        end
    end

    assign q_push          = accept && s_key_end;
    assign q_entry.hash    = hash_next;
    assign q_entry.modulus = bucket_count;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            hash_reg  <= '0;
            start_reg <= 1'b1;
        end else begin
            hash_reg  <= hash_next;
            start_reg <= start_next;
        end
    end

endmodule

### sv/khb_queue.sv
// ----------------------------------------------------------------------------
// khb_queue
// Small FIFO of finished key hashes between intake and reduction.
// ----------------------------------------------------------------------------
module khb_queue #(
    parameter int unsigned DEPTH = 2
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          push,
    input  khb_pkg::khb_entry_t           push_entry,
    input  logic                          pop,
    output khb_pkg::khb_entry_t           head,
    output khb_pkg::khb_queue_stat_t      stat,
    output logic [$clog2(DEPTH+1)-1:0]    count
);
    import khb_pkg::*;

    localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(DEPTH+1);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH-1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

    khb_entry_t          mem_reg [DEPTH];
    logic [PTR_W-1:0]    wr_ptr_reg, rd_ptr_reg;
    logic [CNT_W-1:0]    cnt_reg;
    logic                do_push, do_pop;

    assign stat.full  = (cnt_reg == FULL_CNT);
    assign stat.empty = (cnt_reg == '0);
    assign count      = cnt_reg;
    assign head       = mem_reg[rd_ptr_reg];
    assign do_push    = push && !stat.full;
    assign do_pop     = pop && !stat.empty;

    always_ff @(posedge aclk) begin
        if (do_push) begin
            mem_reg[wr_ptr_reg] <= push_entry;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end else begin
            if (do_push) begin
                wr_ptr_reg <= (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (do_pop) begin
                rd_ptr_reg <= (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (do_push && !do_pop) begin
                cnt_reg <= cnt_reg + 1'b1;
            end else if (do_pop && !do_push) begin
                cnt_reg <= cnt_reg - 1'b1;
            end
        end
    end

endmodule

### sv/khb_back.sv
// ----------------------------------------------------------------------------
// khb_back
// Bucket reduction: restoring remainder, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module khb_back (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  khb_pkg::khb_entry_t           head,
    input  khb_pkg::khb_queue_stat_t      q_stat,
    output logic                          pop,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic [khb_pkg::HASH_W-1:0]    m_bucket_index,
    output khb_pkg::khb_back_stat_t       stat
);
    import khb_pkg::*;

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_RUN  = 2'd1;
    localparam logic [1:0] ST_DONE = 2'd2;
    localparam int unsigned CNT_W  = $clog2(HASH_W);

    logic [1:0]        state_reg, state_next;
    logic [HASH_W-1:0] div_reg, div_next;
    logic [HASH_W-1:0] dvd_reg, dvd_next;
    logic [HASH_W-1:0] rem_reg, rem_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic [HASH_W:0]   trial, diff;

    assign trial = {rem_reg, dvd_reg[HASH_W-1]};
    assign diff  = trial - {1'b0, div_reg};

    always_comb begin
        state_next = state_reg;
        div_next   = div_reg;
        dvd_next   = dvd_reg;
        rem_next   = rem_reg;
        cnt_next   = cnt_reg;
        pop        = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                if (!q_stat.empty) begin
                    pop      = 1'b1;
                    div_next = head.modulus;
                    dvd_next = head.hash;
                    rem_next = '0;
                    cnt_next = CNT_W'(HASH_W-1);
                    state_next = (head.modulus > HASH_W'(1)) ? ST_RUN : ST_DONE;
                end
            end
            ST_RUN: begin
                rem_next = diff[HASH_W] ? trial[HASH_W-1:0] : diff[HASH_W-1:0];
                dvd_next = dvd_reg << 1;
                cnt_next = cnt_reg - 1'b1;
                if (cnt_reg == '0) begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE: begin
                if (m_ready) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign m_valid        = (state_reg == ST_DONE);
    assign m_bucket_index = rem_reg;
    assign stat.busy      = (state_reg == ST_RUN);
    assign stat.divisor   = div_reg;

    always_ff @(posedge aclk) begin
        div_reg <= div_next;
        dvd_reg <= dvd_next;
        rem_reg <= rem_next;
        cnt_reg <= cnt_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule

### sv/key_hash_bucket_index_core.sv
// ----------------------------------------------------------------------------
// key_hash_bucket_index_core
// Byte-key hash with bucket index reduction modulo a programmable count.
// ----------------------------------------------------------------------------
// Input channel s_*: one key byte per item, last byte of the key first.
// s_key_end marks a key's last item; s_byte_present low marks a byteless item.
// Result channel m_*: one bucket index per key, in key order.
// Config channel cfg_*: index 0 is the hash seed, 1 the bucket count; always
// ready, other indexes are dropped. Write only while no key is in flight.
// Throughput: one byte item per cycle while the queue has room. Each key's
// remainder passes through the serial divider as a load step, the bit steps
// and an output step, or only a load and an output step when the bucket
// count is 0 or 1; the divider takes no new key until its result is taken,
// so a stream of short keys is limited by the divider. A key's last item puts
// its hash in the queue; the divider then loads it and, if needed, reduces it.
// Up to QUEUE_DEPTH finished keys wait between the hash stage and the divider.
// Reset: seed and count return to their defaults, the queue empties and the
// next item starts a new key.
// A stalled m_ready holds the result; the queue then fills and s_ready drops.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module key_hash_bucket_index_core #(
    parameter int unsigned QUEUE_DEPTH = 2
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_valid,
    output logic                            s_ready,
    input  logic [7:0]                      s_key_byte,
    input  logic                            s_byte_present,
    input  logic                            s_key_end,
    output logic                            m_valid,
    input  logic                            m_ready,
    output logic [31:0]                     m_bucket_index,
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [khb_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [31:0]                     cfg_data
);
    import khb_pkg::*;

    logic [HASH_W-1:0]               seed_reg;
    logic [HASH_W-1:0]               buckets_reg;
    logic                            q_push, q_pop;
    khb_entry_t                      q_entry, q_head;
    khb_queue_stat_t                 q_stat;
    logic [$clog2(QUEUE_DEPTH+1)-1:0] q_count;
    khb_back_stat_t                  back_stat;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            seed_reg    <= SEED_RESET;
            buckets_reg <= BUCKETS_RESET;
        end else if (cfg_valid && cfg_ready) begin
            if (cfg_index == CFG_HASH_SEED) begin
                seed_reg <= cfg_data;
            end else if (cfg_index == CFG_BUCKET_COUNT) begin
                buckets_reg <= cfg_data;
            end
        end
    end

    khb_front u_front (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_key_byte     (s_key_byte),
        .s_byte_present (s_byte_present),
        .s_key_end      (s_key_end),
        .hash_seed      (seed_reg),
        .bucket_count   (buckets_reg),
        .q_stat         (q_stat),
        .q_push         (q_push),
        .q_entry        (q_entry)
    );

    khb_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (q_push),
        .push_entry (q_entry),
        .pop        (q_pop),
        .head       (q_head),
        .stat       (q_stat),
        .count      (q_count)
    );

    khb_back u_back (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .head           (q_head),
        .q_stat         (q_stat),
        .pop            (q_pop),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_bucket_index (m_bucket_index),
        .stat           (back_stat)
    );

    `KHB_ASSERT(a_queue_bound, aclk, aresetn, q_count <= ($clog2(QUEUE_DEPTH+1))'(QUEUE_DEPTH), "queue count over depth")
    `KHB_ASSERT(a_no_push_full, aclk, aresetn, q_push |-> !q_stat.full, "push into full queue")
    `KHB_ASSERT(a_busy_no_out, aclk, aresetn, back_stat.busy |-> !m_valid, "result shown while dividing")
    `KHB_ASSERT(a_index_range, aclk, aresetn, m_valid |-> (m_bucket_index < back_stat.divisor || back_stat.divisor <= 32'd1), "bucket index not below count")
    `KHB_ASSERT_ALWAYS(a_reset_idle, aclk, !aresetn |=> !m_valid, "result valid after reset")

endmodule

### test/khb_bucket_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// khb_bucket_checker
// Watches the key byte, bucket index and register write channels of the
// bucket index core, predicts each key's bucket index from its own copy of
// the seed, the bucket count and the running hash, and compares every
// accepted index with the oldest prediction. Reports the failure count and
// the number of indexes still outstanding.
// ----------------------------------------------------------------------------
module khb_bucket_checker (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_valid,
    input  logic                          s_ready,
    input  logic [7:0]                    s_key_byte,
    input  logic                          s_byte_present,
    input  logic                          s_key_end,
    input  logic                          m_valid,
    input  logic                          m_ready,
    input  logic [31:0]                   m_bucket_index,
    input  logic                          cfg_valid,
    input  logic                          cfg_ready,
    input  logic [khb_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [31:0]                   cfg_data,
    output int                            failures,
    output int                            outstanding
);
    import khb_pkg::*;

    localparam int REPORT_LIMIT = 10;

    logic [31:0] seed_reg;
    logic [31:0] count_reg;
    logic [31:0] hash_acc;
    logic        at_start;
    logic [31:0] expected_buckets[$];

    function automatic logic [31:0] fold_byte(input logic [31:0] h, input logic [7:0] b);
        logic [31:0] t;
        t = h + {h[26:0], 5'b0};
        t = t ^ {24'b0, b};
        return {1'b0, t[30:0]};
    endfunction

    function automatic logic [31:0] bucket_of(input logic [31:0] h, input logic [31:0] n);
        if (n > 32'd1) begin
            return h % n;
        end
        return 32'd0;
    endfunction

    initial begin
        failures    = 0;
        outstanding = 0;
        seed_reg    = SEED_RESET;
        count_reg   = BUCKETS_RESET;
        hash_acc    = '0;
        at_start    = 1'b1;
    end

    always @(posedge aclk) begin
        logic [31:0] want;
        if (!aresetn) begin
            seed_reg  = SEED_RESET;
            count_reg = BUCKETS_RESET;
            hash_acc  = '0;
            at_start  = 1'b1;
            expected_buckets.delete();
        end else begin
            if (cfg_valid && cfg_ready) begin
                if (cfg_index == CFG_HASH_SEED) begin
                    seed_reg = cfg_data;
                end else if (cfg_index == CFG_BUCKET_COUNT) begin
                    count_reg = cfg_data;
                end
            end
            if (m_valid && m_ready) begin
                if (expected_buckets.size() == 0) begin
                    if (failures < REPORT_LIMIT) begin
                        $display("unexpected bucket_index %0d", m_bucket_index);
                    end
                    failures++;
                end else begin
                    want = expected_buckets.pop_front();
                    if (m_bucket_index !== want) begin
                        if (failures < REPORT_LIMIT) begin
                            $display("bucket_index mismatch: expected %0d got %0d",
                                     want, m_bucket_index);
                        end
                        failures++;
                    end
                end
            end
            if (s_valid && s_ready) begin
                if (at_start) begin
                    hash_acc = seed_reg;
                    at_start = 1'b0;
                end
                if (s_byte_present) begin
                    hash_acc = fold_byte(hash_acc, s_key_byte);
                end
                if (s_key_end) begin
                    at_start = 1'b1;
                    expected_buckets.push_back(bucket_of(hash_acc, count_reg));
                end
            end
        end
        outstanding = expected_buckets.size();
    end

endmodule

### test/tb_key_hash_bucket_index_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_key_hash_bucket_index_core
// Drives keys into the bucket index core one byte per item under random
// sender gaps and receiver stalls, reprograms seed and bucket count between
// phases (extremes and random values), and gives the verdict from the
// checker's failure and outstanding counts.
// ----------------------------------------------------------------------------
module tb_key_hash_bucket_index_core;
    import khb_pkg::*;

    localparam int LIMIT_CYCLES = 1000000;
    localparam int DRAIN_CYCLES = 48;
    localparam int PHASE_ITEMS  = 170;
    localparam int NUM_SETTINGS = 7;

    typedef enum int {KEY_PLAIN, KEY_EMPTY, KEY_SPARSE} key_kind_t;

    logic                 aclk;
    logic                 aresetn;
    logic                 s_valid;
    logic                 s_ready;
    logic [7:0]           s_key_byte;
    logic                 s_byte_present;
    logic                 s_key_end;
    logic                 m_valid;
    logic                 m_ready = 1'b0;
    logic [31:0]          m_bucket_index;
    logic                 cfg_valid;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [31:0]          cfg_data;

    int failures;
    int outstanding;
    int send_idle;
    int recv_idle;
    int cycles;
    int items_sent;

    logic [31:0] seed_set[NUM_SETTINGS] = '{32'hffff_ffff, 32'hffff_ffff, 32'h0000_0000,
                                           32'hffff_ffff, 32'h7fff_ffff, 32'h8000_0000,
                                           32'h1234_5678};
    logic [31:0] count_set[NUM_SETTINGS] = '{32'd0, 32'd1, 32'hffff_ffff, 32'hffff_ffff,
                                            32'd2, 32'h8000_0000, 32'd3};

    key_hash_bucket_index_core dut (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_key_byte     (s_key_byte),
        .s_byte_present (s_byte_present),
        .s_key_end      (s_key_end),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_bucket_index (m_bucket_index),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data)
    );

    khb_bucket_checker u_checker (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_key_byte     (s_key_byte),
        .s_byte_present (s_byte_present),
        .s_key_end      (s_key_end),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_bucket_index (m_bucket_index),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .failures       (failures),
        .outstanding    (outstanding)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    initial begin
        cycles = 0;
    end

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles >= LIMIT_CYCLES) begin
            $display("FAIL key_hash_bucket_index_core");
            $finish;
        end
    end

    always @(negedge aclk) begin
        m_ready <= ($urandom_range(0, 99) >= recv_idle);
    end

    task automatic push_item(input logic [7:0] b, input logic present, input logic last);
        while ($urandom_range(0, 99) < send_idle) begin
            s_valid <= 1'b0;
            @(negedge aclk);
        end
        s_valid        <= 1'b1;
        s_key_byte     <= b;
        s_byte_present <= present;
        s_key_end      <= last;
        do @(posedge aclk); while (!s_ready);
        @(negedge aclk);
        items_sent++;
    endtask

    task automatic send_key(input key_kind_t kind);
        int len;
        case (kind)
            KEY_EMPTY: begin
                push_item(8'($urandom), 1'b0, 1'b1);
            end
            KEY_SPARSE: begin
                len = $urandom_range(1, 6);
                for (int pos = 0; pos < len; pos++) begin
                    push_item(8'($urandom), 1'($urandom_range(0, 1)), pos == len - 1);
                end
            end
            default: begin
                len = $urandom_range(1, 12);
                for (int pos = 0; pos < len; pos++) begin
                    push_item(8'($urandom), 1'b1, pos == len - 1);
                end
            end
        endcase
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do @(posedge aclk); while (!cfg_ready);
        @(negedge aclk);
        cfg_valid <= 1'b0;
        @(negedge aclk);
    endtask

    task automatic wait_idle();
        s_valid <= 1'b0;
        while (outstanding != 0) @(negedge aclk);
        repeat (DRAIN_CYCLES) @(negedge aclk);
    endtask

    initial begin
        int pick;
        int target;
        logic [31:0] seed_val;
        logic [31:0] count_val;

        aresetn        = 1'b0;
        s_valid        = 1'b0;
        s_key_byte     = '0;
        s_byte_present = 1'b0;
        s_key_end      = 1'b0;
        cfg_valid      = 1'b0;
        cfg_index      = '0;
        cfg_data       = '0;
        send_idle      = 12;
        recv_idle      = 61;
        items_sent     = 0;
        repeat (12) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // reset register values
        push_item(8'h00, 1'b1, 1'b1);
        push_item(8'hff, 1'b1, 1'b1);
        push_item(8'h5a, 1'b0, 1'b1);
        push_item(8'h33, 1'b0, 1'b0);
        push_item(8'h61, 1'b1, 1'b0);
        push_item(8'hc3, 1'b0, 1'b0);
        push_item(8'h62, 1'b1, 1'b1);
        push_item(8'h7e, 1'b1, 1'b0);
        push_item(8'h81, 1'b0, 1'b1);
        for (int pos = 0; pos < 8; pos++) begin
            push_item(8'hff, 1'b1, pos == 7);
        end
        wait_idle();

        write_reg(CFG_HASH_SEED, 32'hffff_ffff);
        write_reg(CFG_BUCKET_COUNT, 32'hffff_ffff);
        write_reg(8'hff, 32'h0000_0005);
        push_item(8'h00, 1'b0, 1'b1);
        push_item(8'hff, 1'b1, 1'b1);
        push_item(8'h00, 1'b1, 1'b0);
        push_item(8'hff, 1'b1, 1'b1);
        wait_idle();

        for (int mode = 0; mode < 3; mode++) begin
            case (mode)
                0: begin
                    send_idle = 12;
                    recv_idle = 61;
                end
                1: begin
                    send_idle = 61;
                    recv_idle = 12;
                end
                default: begin
                    send_idle = 0;
                    recv_idle = 0;
                end
            endcase
            for (int sub = 0; sub < 4; sub++) begin
                if (mode * 4 + sub < NUM_SETTINGS) begin
                    seed_val  = seed_set[mode * 4 + sub];
                    count_val = count_set[mode * 4 + sub];
                end else begin
                    seed_val  = $urandom;
                    count_val = ($urandom_range(0, 3) == 0) ? $urandom
                                                            : $urandom_range(0, 5000);
                end
                write_reg(CFG_HASH_SEED, seed_val);
                write_reg(CFG_BUCKET_COUNT, count_val);
                write_reg(CFG_IDX_W'($urandom_range(2, 255)), $urandom);
                target = items_sent + PHASE_ITEMS;
                while (items_sent < target) begin
                    pick = $urandom_range(0, 99);
                    if (pick < 6) begin
                        send_key(KEY_EMPTY);
                    end else if (pick < 16) begin
                        send_key(KEY_SPARSE);
                    end else begin
                        send_key(KEY_PLAIN);
                    end
                end
                wait_idle();
            end
        end

        if (failures == 0 && outstanding == 0) begin
            $display("PASS key_hash_bucket_index_core");
        end else begin
            $display("FAIL key_hash_bucket_index_core");
        end
        $finish;
    end

endmodule
